FILE: src/ira_pkg.sv
// Package for the interval room allocator: widths and payload types.
`default_nettype none
package ira_pkg;
    localparam int MAX_ROOMS_DEF = 256;
    localparam int DAY_BITS_DEF  = 32;
    localparam int IN_DAY_W      = 32;
    localparam int TAG_W         = 16;
    localparam int ROOM_W        = 9;

    typedef struct packed {
        logic              start_batch;
        logic [IN_DAY_W-1:0] arrive_day;
        logic [IN_DAY_W-1:0] depart_day;
        logic [TAG_W-1:0]  guest_index;
    } in_item_t;

    typedef struct packed {
        logic [TAG_W-1:0]  guest_tag;
        logic [ROOM_W-1:0] room_number;
        logic [ROOM_W-1:0] rooms_used;
        logic              overflow;
    } out_item_t;
endpackage
`default_nettype wire

FILE: src/ira_heap_ram.sv
// Heap entry storage: one write port, one registered read port.
`default_nettype none
module ira_heap_ram #(
    parameter int DEPTH  = 256,
    parameter int AW     = 8,
    parameter int DW     = 41
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data
);
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

FILE: src/interval_room_allocator.sv
// Top level: interval partitioning with a min-heap of (departure, room) in RAM.
//
// One request at a time. The request goes through accept, heap-top read and decide
// before its decision. A sift-down then steps through each level with a left child
// read, a right child read, and a write and descend. A level with only a left child
// skips the right child read. One final write ends the sift. A sift-up takes a
// parent read and a compare-and-write per level and is shorter. The heap RAM has
// one write port and one registered read port. The result sits in an output register.
// The next request is accepted once the sift is done, even while that result waits.
// That request then holds at its decision until the output register is free.
// The heap RAM needs no clear; only entries below the heap size are read.
`default_nettype none
module interval_room_allocator
    import ira_pkg::*;
#(
    parameter int MAX_ROOMS = MAX_ROOMS_DEF,
    parameter int DAY_BITS  = DAY_BITS_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);
    localparam int AW = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
    localparam int SW = $clog2(MAX_ROOMS + 1);
    localparam int DW = DAY_BITS + SW;

    // state codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TOP   = 3'd1;
    localparam logic [2:0] ST_DECIDE= 3'd2;
    localparam logic [2:0] ST_LEFT  = 3'd3;
    localparam logic [2:0] ST_RIGHT = 3'd4;
    localparam logic [2:0] ST_DOWN  = 3'd5;
    localparam logic [2:0] ST_UPRD  = 3'd6;
    localparam logic [2:0] ST_UP    = 3'd7;

    typedef struct packed {
        logic [DAY_BITS-1:0] dep;
        logic [SW-1:0]       room;
    } entry_t;

    function automatic logic less_f(entry_t a, entry_t b);
        return (a.dep < b.dep) || ((a.dep == b.dep) && (a.room < b.room));
    endfunction

    logic [2:0]          st_reg, st_next;
    logic [SW-1:0]       size_reg, size_next;
    logic [SW-1:0]       cnt_reg, cnt_next;
    logic [SW:0]         pos_reg, pos_next;      // one extra bit for child indexes
    entry_t              cur_reg, cur_next;      // entry being sifted
    entry_t              best_reg, best_next;
    logic [SW:0]         bpos_reg, bpos_next;
    logic [DAY_BITS-1:0] arr_reg, arr_next;
    logic [TAG_W-1:0]    tag_reg, tag_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_data_reg, m_data_next;

    logic                wr_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    entry_t              wr_data, rd_data;
    logic [SW:0]         lpos, rpos, upos;

    ira_heap_ram #(.DEPTH(MAX_ROOMS), .AW(AW), .DW(DW)) u_ram (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    assign lpos    = {pos_reg[SW-1:0], 1'b1};
    assign rpos    = lpos + (SW+1)'(1);
    assign upos    = (pos_reg - (SW+1)'(1)) >> 1;
    assign s_ready = (st_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // control sequencer
    always_comb begin
        st_next      = st_reg;
        size_next    = size_reg;
        cnt_next     = cnt_reg;
        pos_next     = pos_reg;
        cur_next     = cur_reg;
        best_next    = best_reg;
        bpos_next    = bpos_reg;
        arr_next     = arr_reg;
        tag_next     = tag_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        wr_en        = 1'b0;
        wr_addr      = pos_reg[AW-1:0];
        wr_data      = cur_reg;
        rd_addr      = '0;
        unique case (st_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    arr_next     = DAY_BITS'(s_data.arrive_day);
                    cur_next.dep = DAY_BITS'(s_data.depart_day);
                    tag_next     = s_data.guest_index;
                    if (s_data.start_batch) begin
                        size_next = '0;
                        cnt_next  = '0;
                    end
                    st_next = ST_TOP;
                end
            end
            ST_TOP: begin
                st_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (m_valid_reg && !m_ready) begin
                    // previous result still waiting; heap top keeps being re-read
                    st_next = ST_DECIDE;
                end else begin
                    m_data_next.guest_tag = tag_reg;
                    m_data_next.overflow  = 1'b0;
                    m_valid_next          = 1'b1;
                    if (size_reg != '0 && arr_reg > rd_data.dep) begin
                        cur_next.room           = rd_data.room;
                        m_data_next.room_number = ROOM_W'(rd_data.room);
                        m_data_next.rooms_used  = ROOM_W'(cnt_reg);
                        pos_next = '0;
                        rd_addr  = AW'(1);
                        st_next  = (size_reg > SW'(1)) ? ST_LEFT : ST_DOWN;
                    end else if (size_reg >= SW'(MAX_ROOMS)) begin
                        m_data_next.room_number = '0;
                        m_data_next.rooms_used  = ROOM_W'(cnt_reg);
                        m_data_next.overflow    = 1'b1;
                        st_next = ST_IDLE;
                    end else begin
                        cnt_next                = cnt_reg + SW'(1);
                        cur_next.room           = cnt_reg + SW'(1);
                        m_data_next.room_number = ROOM_W'(cnt_reg + SW'(1));
                        m_data_next.rooms_used  = ROOM_W'(cnt_reg + SW'(1));
                        pos_next  = {1'b0, size_reg};
                        size_next = size_reg + SW'(1);
                        st_next   = ST_UPRD;
                    end
                end
            end
            ST_LEFT: begin
                // left child data valid now
                best_next = cur_reg;
                bpos_next = pos_reg;
                if (less_f(rd_data, cur_reg)) begin
                    best_next = rd_data;
                    bpos_next = lpos;
                end
                rd_addr = rpos[AW-1:0];
                st_next = (rpos < {1'b0, size_reg}) ? ST_RIGHT : ST_DOWN;
                if (rpos >= {1'b0, size_reg}) begin
                    if (less_f(rd_data, cur_reg)) begin
                        best_next = rd_data;
                        bpos_next = lpos;
                    end
                end
            end
            ST_RIGHT: begin
                if (less_f(rd_data, best_reg)) begin
                    best_next = rd_data;
                    bpos_next = rpos;
                end
                st_next = ST_DOWN;
            end
            ST_DOWN: begin
                if (lpos >= {1'b0, size_reg} || bpos_reg == pos_reg) begin
                    wr_en   = 1'b1;
                    st_next = ST_IDLE;
                end else begin
                    // move smaller child up, descend
                    wr_en    = 1'b1;
                    wr_data  = best_reg;
                    pos_next = bpos_reg;
                    rd_addr  = AW'({bpos_reg[SW-1:0], 1'b1});
                    bpos_next = bpos_reg;
                    st_next  = ({bpos_reg[SW-1:0], 1'b1} < {1'b0, size_reg}) ?
                               ST_LEFT : ST_DOWN;
                    if (({bpos_reg[SW-1:0], 1'b1} >= {1'b0, size_reg})) begin
                        bpos_next = bpos_reg;
                    end
                end
            end
            ST_UPRD: begin
                if (pos_reg == '0) begin
                    wr_en   = 1'b1;
                    st_next = ST_IDLE;
                end else begin
                    rd_addr = upos[AW-1:0];
                    st_next = ST_UP;
                end
            end
            ST_UP: begin
                if (less_f(cur_reg, rd_data)) begin
                    wr_en    = 1'b1;
                    wr_data  = rd_data;
                    pos_next = upos;
                    st_next  = ST_UPRD;
                end else begin
                    wr_en   = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            size_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            size_reg    <= size_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        cur_reg    <= cur_next;
        best_reg   <= best_next;
        bpos_reg   <= bpos_next;
        arr_reg    <= arr_next;
        tag_reg    <= tag_next;
        m_data_reg <= m_data_next;
    end

    // checks
    a_size_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        size_reg <= SW'(MAX_ROOMS)) else $error("heap size above capacity");
    a_cnt_size: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == size_reg) else $error("room count and heap size differ");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result dropped");
    a_ovf_room: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.overflow |-> m_data.room_number == '0)
        else $error("overflow with room");
endmodule
`default_nettype wire
